@@ src/bts_pkg.sv @@
`timescale 1ns / 1ps
package bts_pkg;

  // Largest frame dimension; larger register writes saturate here.
  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);

  // Pixel coordinate fields.
  localparam int PIX_W   = 12;

  // Scaled coordinates: centre 20*x+10, and 18*dim for the base vertices.
  localparam int COORD_W = $clog2(20 * (2 ** PIX_W));
  localparam int H18_W   = $clog2(18 * MAX_DIM + 1);
  localparam int DIFF_W  = ((COORD_W > H18_W) ? COORD_W : H18_W) + 1;

  // Product, numerator and denominator widths.
  localparam int PROD_W  = DIM_W + 1 + DIFF_W;
  localparam int NUM_W   = PROD_W + 2;
  localparam int WH_W    = 2 * DIM_W;
  localparam int DEN_W   = WH_W + 5;

  // Colour channels and the restoring divider.
  localparam int CH_N    = 3;
  localparam int Q_W     = 8;
  localparam int DIV_W   = DEN_W + Q_W;

  localparam logic [31:0] ARGB_OPAQUE = 32'hFF00_0000;

  // Queue between front and back.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  // Offsets of the pixel centre from the bottom-right vertex, scaled by 20.
  typedef struct packed {
    logic signed [DIFF_W-1:0] t_y;  // 18h - (20y+10)
    logic signed [DIFF_W-1:0] t_x;  // 18w - (20x+10)
  } q_entry_t;

endpackage

@@ src/bts_front.sv @@
`timescale 1ns / 1ps
module bts_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bts_pkg::DIM_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bts_pkg::PIX_W-1:0]       pixel_x_i,
  input  logic [bts_pkg::PIX_W-1:0]       pixel_y_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output bts_pkg::q_entry_t               q_data_o,
  output bts_pkg::cfg_t                   cfg_o
);
  import bts_pkg::*;

  logic [DIM_W-1:0]   width_q, height_q;
  logic [DIM_W-1:0]   clamped;
  logic [COORD_W-1:0] px, py;
  logic [H18_W-1:0]   w18, h18;

  // Saturate oversized dimensions.
  assign clamped = (cfg_data_i > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  width_q  <= clamped;
        REG_FRAME_HEIGHT: height_q <= clamped;
      endcase
    end
  end

  assign cfg_o.width  = width_q;
  assign cfg_o.height = height_q;

  // Scale the pixel centre and the base vertex by 20 with shifts and adds.
  assign px  = (COORD_W'(pixel_x_i) << 4) + (COORD_W'(pixel_x_i) << 2) + COORD_W'(10);
  assign py  = (COORD_W'(pixel_y_i) << 4) + (COORD_W'(pixel_y_i) << 2) + COORD_W'(10);
  assign w18 = (H18_W'(width_q) << 4) + (H18_W'(width_q) << 1);
  assign h18 = (H18_W'(height_q) << 4) + (H18_W'(height_q) << 1);

  assign q_data_o.t_x = DIFF_W'(w18) - DIFF_W'(px);
  assign q_data_o.t_y = DIFF_W'(h18) - DIFF_W'(py);

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

@@ src/bts_queue.sv @@
`timescale 1ns / 1ps
module bts_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bts_pkg::q_entry_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output bts_pkg::q_entry_t pop_data_o
);
  import bts_pkg::*;

  q_entry_t            slot_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign full_o     = (count_q == QCNT_W'(QDEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH)) else $error("queue count out of range");

endmodule

@@ src/bts_back.sv @@
`timescale 1ns / 1ps
module bts_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bts_pkg::cfg_t     cfg_i,
  input  logic              q_empty_i,
  input  bts_pkg::q_entry_t q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              inside_res_o,
  output logic [31:0]       argb_pixel_o
);
  import bts_pkg::*;

  localparam int STAGES = Q_W;

  typedef struct packed {
    logic signed [PROD_W-1:0] p_wt;   // w * t_y
    logic signed [PROD_W-1:0] p_hu;   // h * t_x
    logic [WH_W-1:0]          wh;
  } mul_t;

  typedef struct packed {
    logic                            hit;
    logic [DEN_W-1:0]                den;
    logic [CH_N-1:0][DEN_W-1:0]      num;
  } comb_t;

  typedef struct packed {
    logic                            hit;
    logic [DEN_W-1:0]                den;
    logic [CH_N-1:0][DIV_W-1:0]      rem;
    logic [CH_N-1:0][Q_W-1:0]        quo;
  } div_t;

  mul_t               mul_q, mul_d;
  comb_t              cmb_q, cmb_d;
  div_t               st_q [STAGES+1];
  div_t               st_d [STAGES+1];
  logic               mul_vld_q, cmb_vld_q;
  logic [STAGES:0]    st_vld_q;
  logic               adv;

  logic signed [NUM_W-1:0] wt_x, hu_x, n_a, n_b, n_c, den_s;

  // Whole back pipeline moves together; the last stage is the output register.
  assign adv     = !st_vld_q[STAGES] || out_ready_i;
  assign q_pop_o = adv && !q_empty_i;

  // Multiply stage.
  always_comb begin
    // red weight uses width, green mixes both
    mul_d.p_wt = $signed({1'b0, cfg_i.width}) * q_data_i.t_y;
    mul_d.p_hu = $signed({1'b0, cfg_i.height}) * q_data_i.t_x;
    mul_d.wh   = cfg_i.width * cfg_i.height;
  end

  // Combine stage: numerators over the common factor 8, and the sign test.
  always_comb begin
    wt_x  = NUM_W'(mul_q.p_wt);
    hu_x  = NUM_W'(mul_q.p_hu);
    den_s = $signed(NUM_W'({mul_q.wh, 5'b0}));
    n_a   = wt_x <<< 1;
    n_b   = (hu_x <<< 1) - wt_x;
    n_c   = den_s - n_a - n_b;
    cmb_d.hit    = !n_a[NUM_W-1] && !n_b[NUM_W-1] && !n_c[NUM_W-1] && (mul_q.wh != '0);
    cmb_d.den    = den_s[DEN_W-1:0];
    cmb_d.num[0] = n_a[DEN_W-1:0];
    cmb_d.num[1] = n_b[DEN_W-1:0];
    cmb_d.num[2] = n_c[DEN_W-1:0];
  end

  // Divider entry: scale each numerator by 255.
  // Restoring division, one quotient bit per stage, most significant first.
  always_comb begin
    st_d[0].hit = cmb_q.hit;
    st_d[0].den = cmb_q.den;
    st_d[0].quo = '0;
    for (int ch = 0; ch < CH_N; ch++) begin
      st_d[0].rem[ch] = (DIV_W'(cmb_q.num[ch]) << 8) - DIV_W'(cmb_q.num[ch]);
    end
    for (int k = 0; k < STAGES; k++) begin
      st_d[k+1] = st_q[k];
      for (int ch = 0; ch < CH_N; ch++) begin
        if (st_q[k].rem[ch] >= (DIV_W'(st_q[k].den) << (Q_W - 1 - k))) begin
          st_d[k+1].rem[ch] = st_q[k].rem[ch] - (DIV_W'(st_q[k].den) << (Q_W - 1 - k));
          st_d[k+1].quo[ch][Q_W-1-k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      cmb_vld_q <= 1'b0;
      st_vld_q  <= '0;
    end else if (adv) begin
      mul_vld_q <= q_pop_o;
      cmb_vld_q <= mul_vld_q;
      st_vld_q  <= {st_vld_q[STAGES-1:0], cmb_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_q <= mul_d;
      cmb_q <= cmb_d;
      for (int s = 0; s <= STAGES; s++) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign out_valid_o  = st_vld_q[STAGES];
  assign inside_res_o = st_q[STAGES].hit;
  assign argb_pixel_o = st_q[STAGES].hit ?
                        (ARGB_OPAQUE | {8'h00, st_q[STAGES].quo[0],
                                        st_q[STAGES].quo[1], st_q[STAGES].quo[2]}) :
                        32'h0;

  a_div_converged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_vld_q[STAGES] && st_q[STAGES].hit) |->
      (st_q[STAGES].rem[0] < DIV_W'(st_q[STAGES].den)) &&
      (st_q[STAGES].rem[1] < DIV_W'(st_q[STAGES].den)) &&
      (st_q[STAGES].rem[2] < DIV_W'(st_q[STAGES].den)))
    else $error("divider remainder not below denominator");

  // Weights sum to one, so the truncated channels sum to 253..255.
  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_vld_q[STAGES] && st_q[STAGES].hit) |->
      ((10'(st_q[STAGES].quo[0]) + 10'(st_q[STAGES].quo[1]) +
        10'(st_q[STAGES].quo[2])) >= 10'd253) &&
      ((10'(st_q[STAGES].quo[0]) + 10'(st_q[STAGES].quo[1]) +
        10'(st_q[STAGES].quo[2])) <= 10'd255))
    else $error("channel sum out of range for inside pixel");

endmodule

@@ src/barycentric_triangle_shader.sv @@
`timescale 1ns / 1ps
// Barycentric shader for one fixed triangle with vertices at (0.5w,0.1h),
// (0.1w,0.9h) and (0.9w,0.9h) of a frame of frame_width x frame_height.
// Input channel: in_valid_i/in_ready_o carry one pixel (pixel_x_i, pixel_y_i).
// Output channel: out_valid_o/out_ready_i carry inside_res_o and argb_pixel_o,
// an opaque ARGB word with each channel weight*255 truncated, or 0 outside.
// Config: cfg_we_i writes cfg_data_i to register cfg_index_i (0 width,
// 1 height) at once; values above 4096 saturate. Write only while idle.
// Throughput: one pixel per cycle, set by the fully pipelined back end, while
// the output is taken. Path: from input accept to out_valid_o the item leaves
// the queue into the multiply register, then combine, divider load and eight
// restoring divider stages (one quotient bit each, all three channels in
// parallel).
// Reset: both dimensions return to 1, the queue empties and all pipeline
// valid flags clear.
// Stall: out_valid_o high with out_ready_i low holds the whole back pipeline;
// the four-entry queue keeps taking items until full, then in_ready_o drops.
module barycentric_triangle_shader (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bts_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bts_pkg::PIX_W-1:0]     pixel_x_i,
  input  logic [bts_pkg::PIX_W-1:0]     pixel_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          inside_res_o,
  output logic [31:0]                   argb_pixel_o
);
  import bts_pkg::*;

  cfg_t     cfg;
  q_entry_t push_data, pop_data;
  logic     q_full, q_empty, q_push, q_pop;

  // Front: hold configuration, offset the pixel centre, push into the queue.
  bts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (push_data),
    .cfg_o       (cfg)
  );

  // Queue: decouple input stalls from output stalls.
  bts_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_data)
  );

  // Back: weights, inside test and pipelined channel division.
  bts_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .q_empty_i    (q_empty),
    .q_data_i     (pop_data),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .inside_res_o (inside_res_o),
    .argb_pixel_o (argb_pixel_o)
  );

endmodule

@@ test/barycentric_triangle_shader_test.sv @@
`timescale 1ns / 1ps
module barycentric_triangle_shader_test;
  import bts_pkg::*;

  // Input accept to output valid.
  localparam int PIPE_LATENCY = 11;
  localparam int RANDOM_ITEMS = 700;
  localparam int REPORT_LIMIT = 10;
  // Results taken before the sink forces its one long hold-off.
  localparam int LONG_HOLD_AT = 150;
  localparam int LONG_HOLD_CYCLES = 120;

  // One result item: inside flag and ARGB word.
  typedef struct packed {
    logic        hit;
    logic [31:0] argb;
  } shade_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_PIXEL
  } row_kind_e;

  // One row of the directed table: a register write or a pixel item. Rows
  // marked typed carry their expected result; the rest use the predictor.
  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [DIM_W-1:0]       data;
    logic [PIX_W-1:0]       x;
    logic [PIX_W-1:0]       y;
    logic                   typed;
    shade_t                 want;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DIM_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [PIX_W-1:0]     pixel_x_i;
  logic [PIX_W-1:0]     pixel_y_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 inside_res_o;
  logic [31:0]          argb_pixel_o;

  // Shadow copy of the frame registers, as the block holds them.
  logic [DIM_W-1:0] cur_width;
  logic [DIM_W-1:0] cur_height;

  shade_t    expected_shades[$];
  stim_row_t directed_rows[$];
  shade_t    oldest_shade;

  int items_sent;
  int results_seen;
  int inside_seen;
  int fault_count;
  int phase_count;

  barycentric_triangle_shader u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .inside_res_o (inside_res_o),
    .argb_pixel_o (argb_pixel_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stop a hung run; the slowest correct run is far shorter than this.
  initial begin
    #3_000_000;
    $display("Timeout with %0d results still pending", expected_shades.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Writes above the largest frame dimension saturate.
  function automatic logic [DIM_W-1:0] saturate_dim(logic [DIM_W-1:0] v);
    return (v > MAX_DIM) ? DIM_W'(MAX_DIM) : v;
  endfunction

  // Truncated weight * 255; num lies in [0, den] and den is positive.
  function automatic logic [7:0] weight_to_channel(longint num, longint den);
    longint q;
    q = (num * 255) / den;
    return (q > 255) ? 8'hFF : q[7:0];
  endfunction

  // Barycentric test of one pixel centre against the fixed triangle, all in
  // coordinates scaled by 20 so that everything stays an exact integer.
  function automatic shade_t shade_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y,
                                         logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    longint wi, hi, px, py;
    longint top_x, top_y, left_x, left_y, right_x, right_y;
    longint den, n0, n1, n2;
    shade_t s;
    wi = w;
    hi = h;
    px = x;
    py = y;
    px = px * 20 + 10;
    py = py * 20 + 10;
    top_x   = 10 * wi;
    top_y   = 2 * hi;
    left_x  = 2 * wi;
    left_y  = 18 * hi;
    right_x = 18 * wi;
    right_y = 18 * hi;
    den = (left_y - right_y) * (top_x - right_x) + (right_x - left_x) * (top_y - right_y);
    n0  = (left_y - right_y) * (px - right_x) + (right_x - left_x) * (py - right_y);
    n1  = (right_y - top_y) * (px - right_x) + (top_x - right_x) * (py - right_y);
    s = '0;
    // A degenerate triangle shades nothing.
    if (den == 0) return s;
    // Flip to a positive denominator so every weight compares against zero.
    if (den < 0) begin
      den = -den;
      n0  = -n0;
      n1  = -n1;
    end
    n2 = den - n0 - n1;
    // Points on an edge count as inside.
    if (n0 < 0 || n1 < 0 || n2 < 0) return s;
    s.hit  = 1'b1;
    s.argb = ARGB_OPAQUE | {8'h00, weight_to_channel(n0, den),
                            weight_to_channel(n1, den), weight_to_channel(n2, den)};
    return s;
  endfunction

  // Mostly back-to-back (always when steady), often a short gap, now and then a long one.
  function automatic int pick_gap(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly small frames so pixels land inside; sometimes large or extreme.
  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return DIM_W'($urandom_range(1, 32));
    if (r < 85) return DIM_W'($urandom_range(33, MAX_DIM));
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return DIM_W'(1);
      2:       return DIM_W'(MAX_DIM);
      default: return DIM_W'($urandom_range(MAX_DIM + 1, 2 ** DIM_W - 1));
    endcase
  endfunction

  // Mostly a coordinate within the frame, otherwise anywhere in the field.
  function automatic logic [PIX_W-1:0] pick_coord(logic [DIM_W-1:0] dim);
    if (dim != 0 && $urandom_range(0, 99) < 80) return PIX_W'($urandom_range(0, dim - 1));
    return PIX_W'($urandom_range(0, 2 ** PIX_W - 1));
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.data = data;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y,
                                    bit typed = 1'b0, shade_t want = '0);
    stim_row_t row;
    row = '0;
    row.kind  = ROW_PIXEL;
    row.x     = x;
    row.y     = y;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // Lower valid over an idle gap of n; n of zero keeps the next item back to back.
  task automatic idle_gap(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
  endtask

  // Offer one pixel item, hold it until accepted, then log its expected result.
  task automatic send_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y,
                            bit typed, shade_t want);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    pixel_x_i  = x;
    pixel_y_i  = y;
    do @(posedge clk_i); while (!in_ready_o);
    expected_shades.push_back(typed ? want : shade_pixel(x, y, cur_width, cur_height));
    items_sent++;
  endtask

  // Stop offering items, wait for every pending result, then let the
  // pipeline settle so the block is idle.
  task automatic drain_results();
    idle_gap(1);
    while (expected_shades.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_FRAME_WIDTH) cur_width = saturate_dim(data);
    else                        cur_height = saturate_dim(data);
  endtask

  // Sink: random ready with steady stretches, plus one long forced hold-off
  // while the sender keeps offering, so the queue fills and in_ready_o drops.
  initial begin : result_sink
    int  hold;
    int  steady_left;
    int  r;
    bit  steady;
    bit  long_done;
    hold        = 0;
    steady_left = 0;
    steady      = 1'b0;
    long_done   = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!long_done && results_seen >= LONG_HOLD_AT) begin
        hold      = LONG_HOLD_CYCLES;
        long_done = 1'b1;
      end
      if (hold > 0) begin
        out_ready_i = 1'b0;
        hold--;
      end else if (steady) begin
        out_ready_i = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ready_i = 1'b1;
        end else if (r < 97) begin
          out_ready_i = 1'b0;
          hold = $urandom_range(0, 2);
        end else begin
          out_ready_i = 1'b0;
          hold = $urandom_range(10, 40);
        end
      end
      // Advance the steady/random stretch schedule.
      if (steady_left == 0) begin
        steady      = ($urandom_range(0, 3) == 0);
        steady_left = $urandom_range(20, 120);
      end else begin
        steady_left--;
      end
    end
  end

  // Compare each accepted result with the oldest pending expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (inside_res_o === 1'b1) inside_seen++;
      if (expected_shades.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("%0t: result with nothing pending: inside %b argb %h",
                   $realtime, inside_res_o, argb_pixel_o);
      end else begin
        oldest_shade = expected_shades.pop_front();
        if (inside_res_o !== oldest_shade.hit || argb_pixel_o !== oldest_shade.argb) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("%0t: result %0d: expected inside %b argb %h, got inside %b argb %h",
                     $realtime, results_seen, oldest_shade.hit, oldest_shade.argb,
                     inside_res_o, argb_pixel_o);
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t        row;
    int               phase_items;
    bit               steady;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = REG_FRAME_WIDTH;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    pixel_x_i    = '0;
    pixel_y_i    = '0;
    cur_width    = DIM_W'(1);
    cur_height   = DIM_W'(1);
    items_sent   = 0;
    results_seen = 0;
    inside_seen  = 0;
    fault_count  = 0;
    phase_count  = 0;

    // Directed table. After reset the frame is one pixel: its centre sits
    // well inside the triangle, everything else lies beyond the frame.
    add_pixel(0, 0, 1'b1, '{1'b1, 32'hFF7F_3F3F});
    add_pixel(12'hFFF, 12'hFFF, 1'b1, '0);
    add_pixel(12'hAAA, 12'h555, 1'b1, '0);
    add_pixel(12'h555, 12'hAAA, 1'b1, '0);
    // Oversized writes saturate to the largest frame.
    add_write(REG_FRAME_WIDTH, '1);
    add_write(REG_FRAME_HEIGHT, '1);
    add_pixel(0, 0);
    add_pixel(2048, 409);
    add_pixel(2047, 410);
    add_pixel(2048, 2048);
    add_pixel(409, 3685);
    add_pixel(3686, 3685);
    add_pixel(2048, 12'hFFF);
    add_pixel(12'hFFF, 12'hFFF);
    // Zero width: degenerate triangle, nothing is inside.
    add_write(REG_FRAME_WIDTH, '0);
    add_pixel(0, 0, 1'b1, '0);
    add_pixel(12'hFFF, 12'hFFF, 1'b1, '0);
    // 5x5 frame: row 4 centres lie exactly on the bottom edge.
    add_write(REG_FRAME_WIDTH, DIM_W'(5));
    add_write(REG_FRAME_HEIGHT, DIM_W'(5));
    add_pixel(2, 4);
    add_pixel(2, 0);
    add_pixel(4, 4);
    // Zero height.
    add_write(REG_FRAME_HEIGHT, '0);
    add_pixel(2, 2, 1'b1, '0);
    // Back to the reset frame.
    add_write(REG_FRAME_WIDTH, DIM_W'(1));
    add_write(REG_FRAME_HEIGHT, DIM_W'(1));
    add_pixel(0, 0, 1'b1, '{1'b1, 32'hFF7F_3F3F});

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table; drain before every register write.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        drain_results();
        write_reg(row.idx, row.data);
      end else begin
        idle_gap(pick_gap(1'b0));
        send_pixel(row.x, row.y, row.typed, row.want);
      end
    end

    // Random phases: drain, pick a frame, then a batch of pixel items.
    while (items_sent < RANDOM_ITEMS) begin
      drain_results();
      write_reg(REG_FRAME_WIDTH, pick_dim());
      write_reg(REG_FRAME_HEIGHT, pick_dim());
      phase_count++;
      steady      = ($urandom_range(0, 3) == 0);
      phase_items = $urandom_range(30, 70);
      for (int n = 0; n < phase_items; n++) begin
        // Once, pause mid-phase until every pending result has come out.
        if (phase_count == 2 && n == phase_items / 2) drain_results();
        x = pick_coord(cur_width);
        y = pick_coord(cur_height);
        idle_gap(pick_gap(steady));
        send_pixel(x, y, 1'b0, '0);
      end
    end

    // Drain, then hold a little longer to catch any stray result.
    drain_results();
    repeat (2 * PIPE_LATENCY) @(posedge clk_i);
    if (expected_shades.size() != 0) fault_count += expected_shades.size();

    $display("Shaded %0d pixels over %0d random frame settings plus the directed table,",
             items_sent, phase_count);
    $display("%0d results inside the triangle, %0d faults.", inside_seen, fault_count);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ barycentric_triangle_shader.f @@
src/bts_pkg.sv
src/bts_front.sv
src/bts_queue.sv
src/bts_back.sv
src/barycentric_triangle_shader.sv
test/barycentric_triangle_shader_test.sv
